[hdl/bbsl_pkg.sv]
// Shared types and constants of the buffered sample logger.
`timescale 1ns / 1ps

package bbsl_pkg;

  localparam int unsigned POOL_BLOCKS_DEF       = 8;
  localparam int unsigned RECORDS_PER_BLOCK_DEF = 16;

  localparam int unsigned SAMPLE_W   = 32;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned REC_CNT_W  = 5;
  localparam int unsigned LOST_W     = 16;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned WRITTEN_W  = 32;
  localparam int unsigned LIMIT_W    = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 32'd256000;
  localparam logic [LOST_W-1:0]  LOST_MAX  = 16'hFFFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_HDR = 2'd0,
    KIND_REC = 2'd1,
    KIND_FIN = 2'd2
  } kind_e;

  // write strobes into the block store
  typedef struct packed {
    logic rec_we;
    logic meta_we;
  } st_wr_t;

endpackage

[hdl/bbsl_in_if.sv]
// Input channel: one logged interval per word.
`timescale 1ns / 1ps

interface bbsl_in_if;
  logic                          valid;
  logic                          ready;
  logic                          stop_request;
  logic [bbsl_pkg::SAMPLE_W-1:0] sample;
  logic                          writer_busy;

  modport source (output valid, output stop_request, output sample, output writer_busy,
                  input ready);
  modport sink   (input valid, input stop_request, input sample, input writer_busy,
                  output ready);
endinterface

[hdl/bbsl_out_if.sv]
// Output channel: headers, records and the finish word.
`timescale 1ns / 1ps

interface bbsl_out_if;
  logic                           valid;
  logic                           ready;
  logic [bbsl_pkg::KIND_W-1:0]    kind;
  logic [bbsl_pkg::SAMPLE_W-1:0]  record_value;
  logic [bbsl_pkg::REC_CNT_W-1:0] record_count;
  logic [bbsl_pkg::LOST_W-1:0]    block_overrun;
  logic [bbsl_pkg::SUM_W-1:0]     total_overruns;
  logic [bbsl_pkg::WRITTEN_W-1:0] blocks_written;
  logic                           last;

  modport source (output valid, output kind, output record_value, output record_count,
                  output block_overrun, output total_overruns, output blocks_written,
                  output last, input ready);
  modport sink   (input valid, input kind, input record_value, input record_count,
                  input block_overrun, input total_overruns, input blocks_written,
                  input last, output ready);
endinterface

[hdl/bbsl_store.sv]
// Block store: record memory and per-block fill/overrun memory, registered reads.
`timescale 1ns / 1ps

module bbsl_store #(
  parameter int unsigned POOL_BLOCKS       = bbsl_pkg::POOL_BLOCKS_DEF,
  parameter int unsigned RECORDS_PER_BLOCK = bbsl_pkg::RECORDS_PER_BLOCK_DEF
) (
  input  logic                                    clk_i,
  input  bbsl_pkg::st_wr_t                        wr_i,
  input  logic [$clog2(POOL_BLOCKS)-1:0]          rec_wr_blk_i,
  input  logic [$clog2(RECORDS_PER_BLOCK+1)-1:0]  rec_wr_idx_i,
  input  logic [bbsl_pkg::SAMPLE_W-1:0]           rec_wr_data_i,
  input  logic [$clog2(POOL_BLOCKS)-1:0]          rec_rd_blk_i,
  input  logic [$clog2(RECORDS_PER_BLOCK+1)-1:0]  rec_rd_idx_i,
  output logic [bbsl_pkg::SAMPLE_W-1:0]           rec_rd_data_o,
  input  logic [$clog2(POOL_BLOCKS)-1:0]          meta_wr_blk_i,
  input  logic [$clog2(RECORDS_PER_BLOCK+1)-1:0]  meta_wr_fill_i,
  input  logic [bbsl_pkg::LOST_W-1:0]             meta_wr_lost_i,
  input  logic [$clog2(POOL_BLOCKS)-1:0]          meta_rd_blk_i,
  output logic [$clog2(RECORDS_PER_BLOCK+1)-1:0]  meta_rd_fill_o,
  output logic [bbsl_pkg::LOST_W-1:0]             meta_rd_lost_o
);
  import bbsl_pkg::*;

  localparam int unsigned FILL_W  = $clog2(RECORDS_PER_BLOCK + 1);
  localparam int unsigned DEPTH   = POOL_BLOCKS * RECORDS_PER_BLOCK;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned META_W  = FILL_W + LOST_W;

  logic [SAMPLE_W-1:0] rec_mem  [DEPTH];
  logic [META_W-1:0]   meta_mem [POOL_BLOCKS];

  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [META_W-1:0] meta_rd_q;

  // block base is a multiply by a small constant
  assign wr_addr = ADDR_W'(rec_wr_blk_i) * ADDR_W'(RECORDS_PER_BLOCK) + ADDR_W'(rec_wr_idx_i);
  assign rd_addr = ADDR_W'(rec_rd_blk_i) * ADDR_W'(RECORDS_PER_BLOCK) + ADDR_W'(rec_rd_idx_i);

  always_ff @(posedge clk_i) begin
    if (wr_i.rec_we) begin
      rec_mem[wr_addr] <= rec_wr_data_i;
    end
    rec_rd_data_o <= rec_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.meta_we) begin
      meta_mem[meta_wr_blk_i] <= {meta_wr_fill_i, meta_wr_lost_i};
    end
    meta_rd_q <= meta_mem[meta_rd_blk_i];
  end

  assign meta_rd_fill_o = meta_rd_q[META_W-1:LOST_W];
  assign meta_rd_lost_o = meta_rd_q[LOST_W-1:0];

endmodule

[hdl/block_buffered_sample_logger_core.sv]
// Buffered sample logger: block pool control, drain sequencer and output register.
//
// smp_i takes one word per log interval: a sticky stop request, a 32-bit sample and
// the writer-busy flag. Samples fill blocks of RECORDS_PER_BLOCK records drawn from
// a pool of POOL_BLOCKS; a full block (or the partial one at stop) is queued for
// draining. With the writer idle, one queued block per input word goes out on res_o
// as a header word followed by its record words; a finish word closes the log at
// stop with nothing queued, or when the written-block count meets the limit.
// The last word caused by an input word carries last = 1.
// The input word is taken in IDLE and the drain decision follows in DECIDE, then
// one result word per cycle while the receiver is ready, records read through the
// single read port of the record memory; smp_i is ready only in IDLE.
// A new input word is accepted while the final result still sits in the output
// register. A stalled receiver holds the sequencer on the pending word.
// cfg_we_i / cfg_wdata_i write the block limit; reset value 256000.
// Reset empties the drain queue, returns all blocks to the free pool and clears
// the counters; after finish, input words are taken and dropped until reset.
`timescale 1ns / 1ps

module block_buffered_sample_logger_core #(
  parameter int unsigned POOL_BLOCKS       = bbsl_pkg::POOL_BLOCKS_DEF,
  parameter int unsigned RECORDS_PER_BLOCK = bbsl_pkg::RECORDS_PER_BLOCK_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bbsl_in_if.sink                      smp_i,
  bbsl_out_if.source                   res_o,
  input  logic                         cfg_we_i,
  input  logic [bbsl_pkg::LIMIT_W-1:0] cfg_wdata_i
);
  import bbsl_pkg::*;

  localparam int unsigned BLK_W  = $clog2(POOL_BLOCKS);
  localparam int unsigned PCNT_W = $clog2(POOL_BLOCKS + 1);
  localparam int unsigned FILL_W = $clog2(RECORDS_PER_BLOCK + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECIDE = 5'b00010,
    ST_META   = 5'b00100,
    ST_REC    = 5'b01000,
    ST_FIN    = 5'b10000
  } st_e;

  st_e state_q, state_d;

  logic                 closing_q, closing_d;
  logic                 finished_q, finished_d;
  logic                 busy_q, busy_d;
  logic                 lim_q, lim_d;
  logic                 cur_valid_q, cur_valid_d;
  logic [BLK_W-1:0]     cur_blk_q, cur_blk_d;
  logic [FILL_W-1:0]    cur_fill_q, cur_fill_d;
  logic [LOST_W-1:0]    cur_lost_q, cur_lost_d;
  logic [LOST_W-1:0]    pending_q, pending_d;
  logic [SUM_W-1:0]     lost_sum_q, lost_sum_d;
  logic [WRITTEN_W-1:0] written_q, written_d;
  logic [LIMIT_W-1:0]   limit_q;
  logic [BLK_W-1:0]     blk_q, blk_d;
  logic [FILL_W-1:0]    idx_q, idx_d;

  logic [BLK_W-1:0]  free_ring_q [POOL_BLOCKS];
  logic [BLK_W-1:0]  full_ring_q [POOL_BLOCKS];
  logic [BLK_W-1:0]  free_head_q, full_head_q;
  logic [PCNT_W-1:0] free_cnt_q, full_cnt_q;

  logic [BLK_W:0]   free_tail_sum, full_tail_sum;
  logic [BLK_W-1:0] free_tail, full_tail;
  logic [BLK_W-1:0] free_head_nxt, full_head_nxt;

  logic              take_free, push_full, pop_full, push_free;
  logic [BLK_W-1:0]  push_full_blk;

  // store connections
  st_wr_t            st_wr;
  logic [BLK_W-1:0]  rec_wr_blk;
  logic [FILL_W-1:0] rec_wr_idx;
  logic [SAMPLE_W-1:0] rec_rd_data;
  logic [FILL_W-1:0] meta_wr_fill;
  logic [LOST_W-1:0] meta_wr_lost;
  logic [BLK_W-1:0]  meta_rd_blk;
  logic [FILL_W-1:0] meta_fill;
  logic [LOST_W-1:0] meta_lost;

  // intake helpers
  logic              acc, stop_now;
  logic [BLK_W-1:0]  use_blk;
  logic [FILL_W-1:0] use_fill, fill_inc;
  logic [LOST_W-1:0] use_lost;

  // header helpers
  logic [SUM_W:0]                 sum_ext;
  logic [SUM_W-1:0]               sum_sat;
  logic [WRITTEN_W-1:0]           written_inc;
  logic                           lim_hit;
  logic [FILL_W+REC_CNT_W-1:0]    cnt_ext;
  logic [FILL_W-1:0]              idx_inc;
  logic                           rec_last;

  // output register
  logic                 out_valid_q, slot_free, load;
  kind_e                o_kind;
  logic [SAMPLE_W-1:0]  o_value;
  logic [REC_CNT_W-1:0] o_count;
  logic [LOST_W-1:0]    o_ovr;
  logic [SUM_W-1:0]     o_sum;
  logic [WRITTEN_W-1:0] o_written;
  logic                 o_last;
  kind_e                kind_q;
  logic [SAMPLE_W-1:0]  value_q;
  logic [REC_CNT_W-1:0] count_q;
  logic [LOST_W-1:0]    ovr_q;
  logic [SUM_W-1:0]     sum_q;
  logic [WRITTEN_W-1:0] written_out_q;
  logic                 last_q;

  assign acc       = smp_i.valid && smp_i.ready;
  assign stop_now  = closing_q || smp_i.stop_request;
  assign slot_free = !out_valid_q || res_o.ready;

  // ring index arithmetic, sums stay below twice the pool size
  assign free_tail_sum = {1'b0, free_head_q} + (BLK_W+1)'(free_cnt_q);
  assign full_tail_sum = {1'b0, full_head_q} + (BLK_W+1)'(full_cnt_q);
  assign free_tail = (free_tail_sum >= (BLK_W+1)'(POOL_BLOCKS)) ?
                     BLK_W'(free_tail_sum - (BLK_W+1)'(POOL_BLOCKS)) : BLK_W'(free_tail_sum);
  assign full_tail = (full_tail_sum >= (BLK_W+1)'(POOL_BLOCKS)) ?
                     BLK_W'(full_tail_sum - (BLK_W+1)'(POOL_BLOCKS)) : BLK_W'(full_tail_sum);
  assign free_head_nxt = (free_head_q == BLK_W'(POOL_BLOCKS - 1)) ? '0 : free_head_q + 1'b1;
  assign full_head_nxt = (full_head_q == BLK_W'(POOL_BLOCKS - 1)) ? '0 : full_head_q + 1'b1;

  // a fresh block starts empty and inherits the pending overrun count
  assign take_free = !cur_valid_q && (free_cnt_q != '0);
  assign use_blk   = take_free ? free_ring_q[free_head_q] : cur_blk_q;
  assign use_fill  = take_free ? '0 : cur_fill_q;
  assign use_lost  = take_free ? pending_q : cur_lost_q;
  assign fill_inc  = use_fill + 1'b1;

  assign sum_ext     = {1'b0, lost_sum_q} + (SUM_W+1)'(meta_lost);
  assign sum_sat     = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  assign written_inc = written_q + 1'b1;
  assign lim_hit     = (written_inc == limit_q);
  assign cnt_ext     = {{REC_CNT_W{1'b0}}, meta_fill};
  assign idx_inc     = idx_q + 1'b1;
  assign rec_last    = (idx_inc == meta_fill);

  assign meta_rd_blk = (state_q == ST_DECIDE) ? full_ring_q[full_head_q] : blk_q;

  always_comb begin
    state_d     = state_q;
    closing_d   = closing_q;
    finished_d  = finished_q;
    busy_d      = busy_q;
    lim_d       = lim_q;
    cur_valid_d = cur_valid_q;
    cur_blk_d   = cur_blk_q;
    cur_fill_d  = cur_fill_q;
    cur_lost_d  = cur_lost_q;
    pending_d   = pending_q;
    lost_sum_d  = lost_sum_q;
    written_d   = written_q;
    blk_d       = blk_q;
    idx_d       = idx_q;

    st_wr         = '0;
    push_full     = 1'b0;
    push_full_blk = use_blk;
    pop_full      = 1'b0;
    push_free     = 1'b0;
    rec_wr_blk    = use_blk;
    rec_wr_idx    = use_fill;
    meta_wr_fill  = fill_inc;
    meta_wr_lost  = use_lost;

    load      = 1'b0;
    o_kind    = KIND_FIN;
    o_value   = '0;
    o_count   = '0;
    o_ovr     = '0;
    o_sum     = lost_sum_q;
    o_written = written_q;
    o_last    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (acc && !finished_q) begin
          closing_d = stop_now;
          busy_d    = smp_i.writer_busy;
          state_d   = ST_DECIDE;
          if (stop_now) begin
            // partial block is queued as it stands
            if (cur_valid_q) begin
              push_full     = 1'b1;
              push_full_blk = cur_blk_q;
              st_wr.meta_we = 1'b1;
              meta_wr_fill  = cur_fill_q;
              meta_wr_lost  = cur_lost_q;
              cur_valid_d   = 1'b0;
            end
          end else if (!cur_valid_q && !take_free) begin
            if (pending_q != LOST_MAX) begin
              pending_d = pending_q + 1'b1;
            end
          end else begin
            if (take_free) begin
              pending_d = '0;
            end
            st_wr.rec_we = 1'b1;
            if (fill_inc == FILL_W'(RECORDS_PER_BLOCK)) begin
              push_full     = 1'b1;
              st_wr.meta_we = 1'b1;
              cur_valid_d   = 1'b0;
            end else begin
              cur_valid_d = 1'b1;
              cur_blk_d   = use_blk;
              cur_fill_d  = fill_inc;
              cur_lost_d  = use_lost;
            end
          end
        end
      end
      ST_DECIDE: begin
        idx_d = '0;
        if (full_cnt_q == '0) begin
          if (closing_q) begin
            finished_d = 1'b1;
            state_d    = ST_FIN;
          end else begin
            state_d = ST_IDLE;
          end
        end else if (!busy_q) begin
          pop_full = 1'b1;
          blk_d    = full_ring_q[full_head_q];
          state_d  = ST_META;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_META: begin
        idx_d = '0;
        if (slot_free) begin
          load       = 1'b1;
          o_kind     = KIND_HDR;
          o_count    = cnt_ext[REC_CNT_W-1:0];
          o_ovr      = meta_lost;
          o_sum      = sum_sat;
          o_written  = written_inc;
          o_last     = (meta_fill == '0) && !lim_hit;
          lost_sum_d = sum_sat;
          written_d  = written_inc;
          lim_d      = lim_hit;
          push_free  = 1'b1;
          if (lim_hit) begin
            finished_d = 1'b1;
          end
          if (meta_fill != '0) begin
            state_d = ST_REC;
          end else if (lim_hit) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_REC: begin
        if (slot_free) begin
          load    = 1'b1;
          o_kind  = KIND_REC;
          o_value = rec_rd_data;
          o_last  = rec_last && !lim_q;
          idx_d   = idx_inc;
          if (rec_last) begin
            state_d = lim_q ? ST_FIN : ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          load    = 1'b1;
          o_kind  = KIND_FIN;
          o_last  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      closing_q   <= 1'b0;
      finished_q  <= 1'b0;
      busy_q      <= 1'b0;
      lim_q       <= 1'b0;
      cur_valid_q <= 1'b0;
      pending_q   <= '0;
      lost_sum_q  <= '0;
      written_q   <= '0;
      limit_q     <= LIMIT_RST;
      free_head_q <= '0;
      free_cnt_q  <= PCNT_W'(POOL_BLOCKS);
      full_head_q <= '0;
      full_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < POOL_BLOCKS; i++) begin
        free_ring_q[i] <= BLK_W'(i);
      end
    end else begin
      state_q     <= state_d;
      closing_q   <= closing_d;
      finished_q  <= finished_d;
      busy_q      <= busy_d;
      lim_q       <= lim_d;
      cur_valid_q <= cur_valid_d;
      pending_q   <= pending_d;
      lost_sum_q  <= lost_sum_d;
      written_q   <= written_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      // take and return never land in the same cycle
      if (acc && !finished_q && !stop_now && take_free) begin
        free_head_q <= free_head_nxt;
        free_cnt_q  <= free_cnt_q - 1'b1;
      end else if (push_free) begin
        free_ring_q[free_tail] <= blk_q;
        free_cnt_q             <= free_cnt_q + 1'b1;
      end
      if (push_full) begin
        full_cnt_q <= full_cnt_q + 1'b1;
      end else if (pop_full) begin
        full_head_q <= full_head_nxt;
        full_cnt_q  <= full_cnt_q - 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_blk_q  <= cur_blk_d;
    cur_fill_q <= cur_fill_d;
    cur_lost_q <= cur_lost_d;
    blk_q      <= blk_d;
    idx_q      <= idx_d;
    if (push_full) begin
      full_ring_q[full_tail] <= push_full_blk;
    end
    if (load) begin
      kind_q        <= o_kind;
      value_q       <= o_value;
      count_q       <= o_count;
      ovr_q         <= o_ovr;
      sum_q         <= o_sum;
      written_out_q <= o_written;
      last_q        <= o_last;
    end
  end

  bbsl_store #(
    .POOL_BLOCKS       (POOL_BLOCKS),
    .RECORDS_PER_BLOCK (RECORDS_PER_BLOCK)
  ) u_store (
    .clk_i          (clk_i),
    .wr_i           (st_wr),
    .rec_wr_blk_i   (rec_wr_blk),
    .rec_wr_idx_i   (rec_wr_idx),
    .rec_wr_data_i  (smp_i.sample),
    .rec_rd_blk_i   (blk_q),
    .rec_rd_idx_i   (idx_d),
    .rec_rd_data_o  (rec_rd_data),
    .meta_wr_blk_i  (push_full_blk),
    .meta_wr_fill_i (meta_wr_fill),
    .meta_wr_lost_i (meta_wr_lost),
    .meta_rd_blk_i  (meta_rd_blk),
    .meta_rd_fill_o (meta_fill),
    .meta_rd_lost_o (meta_lost)
  );

  assign smp_i.ready         = (state_q == ST_IDLE);
  assign res_o.valid         = out_valid_q;
  assign res_o.kind          = kind_q;
  assign res_o.record_value  = value_q;
  assign res_o.record_count  = count_q;
  assign res_o.block_overrun = ovr_q;
  assign res_o.total_overruns = sum_q;
  assign res_o.blocks_written = written_out_q;
  assign res_o.last          = last_q;

  // every block is free, queued, held for filling or being drained
  a_pool_conserved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(free_cnt_q) + 32'(full_cnt_q) + 32'(cur_valid_q) + 32'(state_q == ST_META))
      == 32'(POOL_BLOCKS))
    else $error("block pool count mismatch");

  a_fin_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.kind == KIND_FIN)) |-> res_o.last)
    else $error("finish word without last");

  a_drop_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && finished_q) |=> (state_q == ST_IDLE) && $stable(written_q))
    else $error("input word processed after finish");

  a_hdr_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && (o_kind == KIND_HDR)) |-> (32'(meta_fill) <= 32'(RECORDS_PER_BLOCK)))
    else $error("header record count exceeds block size");

endmodule
